FILE: design/des_pkg.sv
// Package for the DES block cipher: permutation tables, S-boxes and round functions.
`default_nettype none

package des_pkg;

  // Control bits that travel with a block from one round cell to the next.
  typedef struct packed {
    logic valid;
    logic action;
  } ctl_t;

  localparam int Rounds = 16;

  localparam logic [6:0] INIT_PERM [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FINAL_PERM [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] EXPAND_SEL [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
    6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
    6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
    6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
    6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] ROUND_PERM [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] KEY_SEL1 [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
    7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
    7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] KEY_SEL2 [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [1:0] ROT_AMOUNT [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  // Each box is indexed by {row, column}: row is the outer bit pair.
  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
      4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
      4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
      4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
      4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
      4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
      4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
    '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
      4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
      4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
      4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
      4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
      4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
      4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
      4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
    '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
      4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
      4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
      4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
      4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
      4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
      4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
    '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
      4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
      4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
      4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
      4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
      4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
      4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
      4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
      4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
      4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
      4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
    '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
      4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
      4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
      4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
      4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
      4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
      4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
      4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
    '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
      4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
      4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
      4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
      4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
      4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
      4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
      4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
    '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
      4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
      4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
      4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
      4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
      4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
      4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
      4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
  };

  // Table entries count bit positions from the top of the source word, starting at 1.
  function automatic logic [63:0] init_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[63 - i] = v[64 - int'(INIT_PERM[i])];
    end
    return r;
  endfunction

  function automatic logic [63:0] final_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) begin
      r[63 - i] = v[64 - int'(FINAL_PERM[i])];
    end
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] x, input logic [1:0] s);
    logic [27:0] r;
    if (s == 2'd1) begin
      r = {x[26:0], x[27]};
    end else begin
      r = {x[25:0], x[27:26]};
    end
    return r;
  endfunction

  // Subkey of one round; the round number is a constant at every use, so this is wiring.
  function automatic logic [47:0] subkey(input logic [63:0] key, input int round);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [55:0] cd_rot;
    logic [47:0] k;
    for (int i = 0; i < 56; i++) begin
      cd[55 - i] = key[64 - int'(KEY_SEL1[i])];
    end
    c = cd[55:28];
    d = cd[27:0];
    for (int j = 0; j < Rounds; j++) begin
      if (j <= round) begin
        c = rot28(c, ROT_AMOUNT[j]);
        d = rot28(d, ROT_AMOUNT[j]);
      end
    end
    cd_rot = {c, d};
    for (int i = 0; i < 48; i++) begin
      k[47 - i] = cd_rot[56 - int'(KEY_SEL2[i])];
    end
    return k;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0]  b;
    logic [31:0] s;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) begin
      x[47 - i] = r[32 - int'(EXPAND_SEL[i])];
    end
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47 - 6 * i -: 6];
      s[31 - 4 * i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) begin
      p[31 - i] = s[32 - int'(ROUND_PERM[i])];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: design/des_round_cell.sv
// One DES round cell: a Feistel round followed by the register that hands the block on.
`default_nettype none

module des_round_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic [47:0]   enc_key,
  input  wire logic [47:0]   dec_key,
  input  wire des_pkg::ctl_t ctl_in,
  input  wire logic [31:0]   l_in,
  input  wire logic [31:0]   r_in,
  output des_pkg::ctl_t      ctl_out,
  output logic [31:0]        l_out,
  output logic [31:0]        r_out
);

  des_pkg::ctl_t ctl;
  logic [31:0]   l;
  logic [31:0]   r;
  logic [47:0]   round_key;
  logic [31:0]   r_next;

  assign round_key = ctl_in.action ? enc_key : dec_key;
  assign r_next    = l_in ^ des_pkg::feistel(r_in, round_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (advance) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      l <= r_in;
      r <= r_next;
    end
  end

  assign ctl_out = ctl;
  assign l_out   = l;
  assign r_out   = r;

endmodule

`default_nettype wire

FILE: design/des_block_cipher.sv
// Top level of the DES block cipher: key register, initial permutation and the round cells.
//
// The block runs DES in ECB mode on one 64-bit beat at a time and accepts a new beat in
// every cycle while the output is not stalled. A block passes through a chain of sixteen
// round cells, one per DES round, and each cell registers the block before handing it on.
// The last cell's register holds the result until it is taken; when the output is stalled
// the whole chain holds and in_ready falls. Subkeys are wired from the key register, so
// a new key applies to every block accepted after the write; the user must write the key
// only while no block is in flight, since every round reads the current key. The block
// itself does not enforce this.
`default_nettype none

module des_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        key_we,
  input  wire logic [63:0] key_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [63:0] block_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      block_out
);

  logic [63:0]   cipher_key;
  logic          advance;
  logic [63:0]   ip_block;
  des_pkg::ctl_t ctl_s [des_pkg::Rounds + 1];
  logic [31:0]   l_s   [des_pkg::Rounds + 1];
  logic [31:0]   r_s   [des_pkg::Rounds + 1];
  logic [47:0]   enc_sk [des_pkg::Rounds];
  logic [47:0]   dec_sk [des_pkg::Rounds];

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (key_we) begin
      cipher_key <= key_wdata;
    end
  end

  assign out_valid = ctl_s[des_pkg::Rounds].valid;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;

  assign ip_block     = des_pkg::init_perm(block_in);
  assign ctl_s[0]     = '{valid: in_valid, action: action};
  assign l_s[0]       = ip_block[63:32];
  assign r_s[0]       = ip_block[31:0];

  for (genvar g = 0; g < des_pkg::Rounds; g++) begin : g_round
    assign enc_sk[g] = des_pkg::subkey(cipher_key, g);
    assign dec_sk[g] = des_pkg::subkey(cipher_key, des_pkg::Rounds - 1 - g);

    des_round_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .enc_key (enc_sk[g]),
      .dec_key (dec_sk[g]),
      .ctl_in  (ctl_s[g]),
      .l_in    (l_s[g]),
      .r_in    (r_s[g]),
      .ctl_out (ctl_s[g + 1]),
      .l_out   (l_s[g + 1]),
      .r_out   (r_s[g + 1])
    );
  end

  // The halves swap once more after the last round before the inverse permutation.
  assign block_out = des_pkg::final_perm({r_s[des_pkg::Rounds], l_s[des_pkg::Rounds]});

endmodule

`default_nettype wire

FILE: tb/sv/des_cipher_checker.sv
// Checker for the DES block cipher: predicts each result block and compares it at the output.
`timescale 1ns / 100ps

module des_cipher_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        key_we,
  input  wire logic [63:0] key_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        action,
  input  wire logic [63:0] block_in,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [63:0] block_out,
  output int               fail_count,
  output int               outstanding
);

  logic [63:0] key_shadow;
  logic [63:0] expected_blocks [$];

  // Full DES on one block under the given key; encrypt selects the subkey order.
  function automatic logic [63:0] des_crypt(input logic [63:0] key, input logic encrypt,
                                            input logic [63:0] blk);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [47:0] round_keys [16];
    logic [63:0] t;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] s;
    logic [31:0] f;
    logic [47:0] x;
    logic [5:0]  b;
    logic [63:0] res;
    int          kr;
    for (int i = 0; i < 56; i++) begin
      cd[55 - i] = key[64 - int'(des_pkg::KEY_SEL1[i])];
    end
    c = cd[55:28];
    d = cd[27:0];
    for (int rnd = 0; rnd < 16; rnd++) begin
      for (int n = 0; n < int'(des_pkg::ROT_AMOUNT[rnd]); n++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) begin
        round_keys[rnd][47 - i] = cd[56 - int'(des_pkg::KEY_SEL2[i])];
      end
    end
    for (int i = 0; i < 64; i++) begin
      t[63 - i] = blk[64 - int'(des_pkg::INIT_PERM[i])];
    end
    l = t[63:32];
    r = t[31:0];
    for (int rnd = 0; rnd < 16; rnd++) begin
      kr = encrypt ? rnd : 15 - rnd;
      for (int i = 0; i < 48; i++) begin
        x[47 - i] = r[32 - int'(des_pkg::EXPAND_SEL[i])];
      end
      x = x ^ round_keys[kr];
      for (int j = 0; j < 8; j++) begin
        b = x[47 - 6 * j -: 6];
        // The outer two bits pick the row, the middle four the column.
        s[31 - 4 * j -: 4] = des_pkg::SBOX[j][{b[5], b[0], b[4:1]}];
      end
      for (int i = 0; i < 32; i++) begin
        f[31 - i] = s[32 - int'(des_pkg::ROUND_PERM[i])];
      end
      {l, r} = {r, l ^ f};
    end
    t = {r, l};
    for (int i = 0; i < 64; i++) begin
      res[63 - i] = t[64 - int'(des_pkg::FINAL_PERM[i])];
    end
    return res;
  endfunction

  initial begin
    fail_count  = 0;
    outstanding = 0;
    key_shadow  = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      key_shadow = '0;
      expected_blocks.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected output beat, actual block_out %h", $time, block_out);
          fail_count = fail_count + 1;
        end else begin
          if (block_out !== expected_blocks[0]) begin
            $display("%0t: block_out mismatch, expected %h actual %h",
                     $time, expected_blocks[0], block_out);
            fail_count = fail_count + 1;
          end
          void'(expected_blocks.pop_front());
        end
      end
      // Keys are only written while nothing is in flight, so ordering here is safe.
      if (key_we) begin
        key_shadow = key_wdata;
      end
      if (in_valid && in_ready) begin
        expected_blocks.push_back(des_crypt(key_shadow, action, block_in));
      end
    end
    outstanding = expected_blocks.size();
  end

endmodule

FILE: tb/sv/des_block_cipher_tb.sv
// Testbench top for the DES block cipher: stimulus, flow control phases and the verdict.
`timescale 1ns / 100ps

module des_block_cipher_tb;

  localparam int CycleLimit   = 300000;
  localparam int Segments     = 8;
  localparam int SegmentBeats = 190;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        key_we    = 1'b0;
  logic [63:0] key_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        action    = 1'b0;
  logic [63:0] block_in  = '0;
  logic        out_ready = 1'b1;
  logic        in_ready;
  logic        out_valid;
  logic [63:0] block_out;

  int fail_count;
  int outstanding;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  logic [63:0] directed_keys [4];
  logic [63:0] directed_blocks [3];
  logic [63:0] seg_key;
  logic [63:0] rand_block;

  des_block_cipher DUT (
    .clk       (clk),
    .rst       (rst),
    .key_we    (key_we),
    .key_wdata (key_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .block_in  (block_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .block_out (block_out)
  );

  des_cipher_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .key_we      (key_we),
    .key_wdata   (key_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .block_in    (block_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .block_out   (block_out),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("des_block_cipher_tb: done, errors");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_block(input logic act, input logic [63:0] blk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    block_in <= blk;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_key(input logic [63:0] k);
    key_we    <= 1'b1;
    key_wdata <= k;
    @(negedge clk);
    key_we    <= 1'b0;
  endtask

  initial begin
    directed_keys[0]   = 64'h0;
    directed_keys[1]   = 64'h133457799BBCDFF1;
    directed_keys[2]   = 64'h0101010101010101;
    directed_keys[3]   = 64'h01FE01FE01FE01FE;
    directed_blocks[0] = 64'h0;
    directed_blocks[1] = '1;
    directed_blocks[2] = 64'h0123456789ABCDEF;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The first group runs on the key held since reset; weak keys get no special path.
    for (int k = 0; k < 4; k++) begin
      if (k > 0) begin
        drain_results();
        write_key(directed_keys[k]);
      end
      for (int b = 0; b < 3; b++) begin
        send_block(1'b1, directed_blocks[b]);
        send_block(1'b0, directed_blocks[b]);
      end
    end

    for (int seg = 0; seg < Segments; seg++) begin
      case (seg)
        0: seg_key = '1;
        1: seg_key = '0;
        5: seg_key = 64'hE0E0E0E0F1F1F1F1;
        default: seg_key = {$urandom, $urandom};
      endcase
      drain_results();
      write_key(seg_key);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < SegmentBeats; n++) begin
        case ($urandom_range(9))
          0: rand_block = '0;
          1: rand_block = '1;
          2: rand_block = 64'h1 << $urandom_range(63);
          default: rand_block = {$urandom, $urandom};
        endcase
        send_block(1'($urandom_range(1)), rand_block);
        // Let the pipeline run dry once in the middle of a stalled segment.
        if (seg == 2 && n == SegmentBeats / 2) begin
          drain_results();
        end
      end
    end

    drain_results();
    recv_stall_pct = 0;
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("des_block_cipher_tb: done, clean");
    end else begin
      $display("des_block_cipher_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: des_block_cipher.f
design/des_pkg.sv
design/des_round_cell.sv
design/des_block_cipher.sv
tb/sv/des_cipher_checker.sv
tb/sv/des_block_cipher_tb.sv
